@@ rtl/rss_pkg.sv @@
// Package for the reservoir sampler: shared widths, mode codes and the
// command and status structs between controller and datapath.
// No dependencies.
package rss_pkg;

  // Width of a sample, of a random word and of the seen counter.
  localparam int DW = 64;
  // Width of the held count reported with each result.
  localparam int HW = 7;
  // Width of the divider step counter (one quotient bit per step).
  localparam int DCW = 6;

  // Input mode codes.
  localparam logic [1:0] MODE_UPDATE   = 2'd0;
  localparam logic [1:0] MODE_SNAPSHOT = 2'd1;
  localparam logic [1:0] MODE_CLEAR    = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the item's operands
    logic upd_fill;  // store into the next free slot and count it
    logic div_init;  // set up the modulo and count the value
    logic div_step;  // one restoring division step
    logic repl;      // replace the drawn slot if it is in range
    logic clr;       // zero the seen counter
    logic emit;      // send a result without a sample
    logic rd_clr;    // rewind the read-out pointer
    logic rd_issue;  // read one slot for the snapshot
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic lt_depth;   // fewer values seen than slots
    logic held_zero;  // reservoir empty
    logic div_done;   // this is the final division step
    logic rd_last;    // the pointer sits on the last held slot
  } sts_t;

endpackage

@@ rtl/reservoir_sampler_unit.sv @@
// Top level of the reservoir sampler (Algorithm R): joins the controller
// and the datapath. Depends on rss_pkg, rss_ctrl and rss_dp.
//
//  Channel   Ports                                          Handshake
//  input     in_mode, in_sample_in, in_random_word          start && !busy
//  result    out_sample_out, out_has_sample, out_last,      out_valid, one cycle
//            out_held
//
// An update stores straight into the next free slot while the store is filling;
// once full, a 64-step restoring modulo picks the slot, if any, to replace.
// A snapshot reads one slot per cycle from the store's single read port; clear
// and an empty snapshot each send a single marker result.
// Reset (rst_n low at a clock edge) zeroes the count; slots are only read
// after they have been written since the last clear, so the store needs no
// clearing pass. Results cannot be stalled: each stands for one cycle.
module reservoir_sampler_unit #(
  parameter int DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_mode,
  input  logic signed [rss_pkg::DW-1:0]  in_sample_in,
  input  logic [rss_pkg::DW-1:0]         in_random_word,
  output logic                           out_valid,
  output logic signed [rss_pkg::DW-1:0]  out_sample_out,
  output logic                           out_has_sample,
  output logic                           out_last,
  output logic [rss_pkg::HW-1:0]         out_held
);
  import rss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing of each item.
  rss_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd)
  );

  // Storage, arithmetic and result register.
  rss_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_sample_in   (in_sample_in),
    .in_random_word (in_random_word),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_sample_out (out_sample_out),
    .out_has_sample (out_has_sample),
    .out_last       (out_last),
    .out_held       (out_held)
  );

endmodule

@@ rtl/rss_ctrl.sv @@
// Controller state machine of the reservoir sampler.
// Depends on rss_pkg for the command and status structs and mode codes.
module rss_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [1:0]     in_mode,
  input  rss_pkg::sts_t  sts,
  output logic           busy,
  output rss_pkg::cmd_t  cmd
);
  import rss_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_UPD   = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_REPL  = 3'd3;
  localparam logic [2:0] ST_CLR   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;
  localparam logic [2:0] ST_SNAP  = 3'd6;
  localparam logic [2:0] ST_SWAIT = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign busy = (state_r != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (in_mode)
            MODE_UPDATE: state_nxt = ST_UPD;
            MODE_SNAPSHOT: begin
              cmd.rd_clr = 1'b1;
              state_nxt  = sts.held_zero ? ST_EMIT : ST_SNAP;
            end
            MODE_CLEAR: state_nxt = ST_CLR;
            default: state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_UPD: begin
        if (sts.lt_depth) begin
          cmd.upd_fill = 1'b1;
          state_nxt    = ST_EMIT;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = ST_REPL;
        end
      end
      ST_REPL: begin
        cmd.repl  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_CLR: begin
        cmd.clr   = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SNAP: begin
        cmd.rd_issue = 1'b1;
        if (sts.rd_last) begin
          state_nxt = ST_SWAIT;
        end
      end
      ST_SWAIT: begin
        // Let the final read-out result leave the output register.
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/rss_dp.sv @@
// Datapath of the reservoir sampler: seen counter, sample store, iterative
// modulo unit, read-out pointer and result register. Depends on rss_pkg.
module rss_dp #(
  parameter int DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rss_pkg::cmd_t                  cmd,
  input  logic signed [rss_pkg::DW-1:0]  in_sample_in,
  input  logic [rss_pkg::DW-1:0]         in_random_word,
  output rss_pkg::sts_t                  sts,
  output logic                           out_valid,
  output logic signed [rss_pkg::DW-1:0]  out_sample_out,
  output logic                           out_has_sample,
  output logic                           out_last,
  output logic [rss_pkg::HW-1:0]         out_held
);
  import rss_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Operands, counter and modulo unit.
  logic [DW-1:0]  val_r;
  logic [DW-1:0]  count_r;
  logic [DW-1:0]  dvd_r;
  logic [DW-1:0]  rem_r;
  logic [DW:0]    divisor_r;
  logic [DCW-1:0] div_cnt_r;
  logic [DW:0]    trial;
  logic [DW:0]    diff;
  logic           lt_depth;
  logic [HW-1:0]  held;

  // Sample store and read-out.
  logic [DW-1:0]  mem [DEPTH];
  logic [DW-1:0]  mem_q_r;
  logic [AW-1:0]  rd_ptr_r;
  logic           rd_pend_r;
  logic           rd_last_pend_r;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;

  // Result register.
  logic           out_valid_r;
  logic [DW-1:0]  out_sample_r;
  logic           out_has_r;
  logic           out_last_r;
  logic [HW-1:0]  out_held_r;

  // Held count is min(count, DEPTH).
  assign lt_depth = (count_r < DW'(DEPTH));
  assign held     = lt_depth ? count_r[HW-1:0] : HW'(DEPTH);

  assign sts.lt_depth  = lt_depth;
  assign sts.held_zero = (count_r == '0);
  assign sts.div_done  = (div_cnt_r == '1);
  assign sts.rd_last   = ((HW'(rd_ptr_r) + HW'(1)) == held);

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign trial = {rem_r, dvd_r[DW-1]};
  assign diff  = trial - divisor_r;

  // Capture operands, run the counter and the modulo unit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      if (cmd.upd_fill) begin
        count_r <= count_r + DW'(1);
      end else if (cmd.div_init) begin
        // The count saturates at its maximum.
        if (count_r != '1) begin
          count_r <= count_r + DW'(1);
        end
      end else if (cmd.clr) begin
        count_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r <= in_sample_in;
      dvd_r <= in_random_word;
    end
    if (cmd.div_init) begin
      // A saturated count gives a modulus of 2^64, leaving the word as is.
      divisor_r <= {1'b0, count_r} + (DW + 1)'(1);
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r     <= (trial >= divisor_r) ? diff[DW-1:0] : trial[DW-1:0];
      dvd_r     <= {dvd_r[DW-2:0], 1'b0};
      div_cnt_r <= div_cnt_r + DCW'(1);
    end
  end

  // Store write: next free slot while filling, drawn slot afterwards.
  assign wr_en   = cmd.upd_fill || (cmd.repl && (rem_r < DW'(DEPTH)));
  assign wr_addr = cmd.upd_fill ? count_r[AW-1:0] : rem_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= val_r;
    end
    if (cmd.rd_issue) begin
      mem_q_r <= mem[rd_ptr_r];
    end
  end

  // Read-out pointer and the pending flags that follow the read latency.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.rd_issue;
    end
    if (cmd.rd_clr) begin
      rd_ptr_r <= '0;
    end else if (cmd.rd_issue) begin
      rd_ptr_r <= rd_ptr_r + AW'(1);
    end
    rd_last_pend_r <= sts.rd_last;
  end

  // Result register: a read-out sample or a marker item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit || rd_pend_r;
    end
    if (rd_pend_r) begin
      out_sample_r <= mem_q_r;
      out_has_r    <= 1'b1;
      out_last_r   <= rd_last_pend_r;
    end else begin
      out_sample_r <= '0;
      out_has_r    <= 1'b0;
      out_last_r   <= 1'b1;
    end
    out_held_r <= held;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_has_sample = out_has_r;
  assign out_last       = out_last_r;
  assign out_held       = out_held_r;

endmodule

@@ rtl/rss_checker.sv @@
// Port-level checker for the reservoir sampler, bound to the top level.
// Depends on rss_pkg and reservoir_sampler_unit.
module rss_checker #(
  parameter int DEPTH = 64
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic                   out_valid,
  input logic                   out_has_sample,
  input logic                   out_last,
  input logic [rss_pkg::HW-1:0] out_held
);
  import rss_pkg::*;

  // A marker item is always the only result of its item.
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_sample |-> out_last)
    else $error("marker item without last");

  // Held count at most DEPTH; samples only from a non-empty reservoir.
  a_sample_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_held <= HW'(DEPTH)) &&
                  (!out_has_sample || out_held != '0))
    else $error("held count out of range");

  // A snapshot streams without gaps until its last item.
  a_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_sample && !out_last |=> out_valid && out_has_sample)
    else $error("gap in snapshot stream");

  // After a last item, another result needs a fresh accept first.
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result right after last item");

  // An accepted item keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("not busy after accept");

endmodule

bind reservoir_sampler_unit rss_checker #(
  .DEPTH (DEPTH)
) u_rss_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_has_sample (out_has_sample),
  .out_last       (out_last),
  .out_held       (out_held)
);
